// File: hdl/crrp_pkg.sv
// Shared types and constants for the cell range reference parser.
// Depends on nothing; every module of the block imports it.
package crrp_pkg;

    // Port and field widths
    localparam int CHAR_W      = 8;
    localparam int ROW_W       = 20;
    localparam int COL_W       = 14;
    localparam int CNT_W       = 35;
    localparam int OUT_BITS    = 1 + 2 + ROW_W + COL_W + ROW_W + COL_W + CNT_W;
    localparam int TDATA_OUT_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int PAD_W       = TDATA_OUT_W - OUT_BITS;

    // Split point of the cell count multiply
    localparam int SPLIT = 18;

    // Radixes of the column letters and the row digits
    localparam int COL_RADIX = 26;
    localparam int ROW_RADIX = 10;

    // Character codes
    localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
    localparam logic [CHAR_W-1:0] CH_Z     = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;

    // Parse phase, one-hot
    typedef enum logic [5:0] {
        PH_FIRST_START   = 6'b000001,
        PH_FIRST_LETTERS = 6'b000010,
        PH_FIRST_DIGITS  = 6'b000100,
        PH_SECOND_START  = 6'b001000,
        PH_SECOND_LETTERS= 6'b010000,
        PH_SECOND_DIGITS = 6'b100000
    } t_phase;

    // Error codes
    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_MALFORMED = 2'd1,
        ERR_LIMIT     = 2'd2
    } t_err;

    // Result fields other than the cell count
    typedef struct packed {
        logic             valid_res;
        t_err             error_code;
        logic [ROW_W-1:0] from_row;
        logic [COL_W-1:0] from_column;
        logic [ROW_W-1:0] to_row;
        logic [COL_W-1:0] to_column;
    } t_corners;

    // Finished parse: corners plus the two spans to multiply
    typedef struct packed {
        t_corners         corners;
        logic [CNT_W-1:0] col_span;
        logic [CNT_W-1:0] row_span;
    } t_result;

endpackage

// File: hdl/crrp_parse.sv
// Per-character parser: phase, accumulators, first corner and error state.
// Produces the finished result for the character marked last. Uses crrp_pkg.
module crrp_parse #(
    parameter int ROW_BITS    = 20,
    parameter int COLUMN_BITS = 14
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_take,
    input  logic [crrp_pkg::CHAR_W-1:0]   i_char,
    input  logic                          i_last,
    input  logic                          i_range_mode,
    output crrp_pkg::t_result             o_result
);
    import crrp_pkg::*;

    // Accumulators hold up to limit + 1; products get headroom for one step
    localparam int CAW = COLUMN_BITS + 2;
    localparam int CMW = COLUMN_BITS + 5;
    localparam int RAW = ROW_BITS + 2;
    localparam int RMW = ROW_BITS + 4;

    localparam logic [CAW-1:0] CLIM = CAW'({1'b1, {COLUMN_BITS{1'b0}}});
    localparam logic [RAW-1:0] RLIM = RAW'({1'b1, {ROW_BITS{1'b0}}});

    t_phase                 r_phase, n_phase;
    t_err                   r_err, n_err;
    logic [CAW-1:0]         r_cacc, n_cacc;
    logic [RAW-1:0]         r_racc, n_racc;
    logic [ROW_BITS-1:0]    r_fr, n_fr;
    logic [COLUMN_BITS-1:0] r_fc, n_fc;

    logic                   is_letter, is_digit, is_colon;
    logic                   letter_ok, digit_ok;
    logic [CMW-1:0]         col_mac;
    logic [RMW-1:0]         row_mac;
    logic [CAW-1:0]         col_sat, cur_cdec, fin_cdec;
    logic [RAW-1:0]         row_sat, cur_rdec, fin_rdec;
    t_phase                 want_phase;
    t_err                   fin_err;
    logic [COLUMN_BITS-1:0] c1, c2, c_lo, c_hi;
    logic [ROW_BITS-1:0]    r1, r2, r_lo, r_hi;
    logic [COLUMN_BITS:0]   c_span;
    logic [ROW_BITS:0]      r_span;

    function automatic logic addr_in_limit(input logic [CAW-1:0] c, input logic [RAW-1:0] r);
        return !(c > CLIM || r == '0 || r > RLIM);
    endfunction

    // Classify the character
    assign is_letter = (i_char >= CH_A) && (i_char <= CH_Z);
    assign is_digit  = (i_char >= CH_0) && (i_char <= CH_9);
    assign is_colon  = (i_char == CH_COLON);

    assign letter_ok = (r_phase == PH_FIRST_START) || (r_phase == PH_FIRST_LETTERS) ||
                       (r_phase == PH_SECOND_START) || (r_phase == PH_SECOND_LETTERS);
    assign digit_ok  = (r_phase == PH_FIRST_LETTERS) || (r_phase == PH_FIRST_DIGITS) ||
                       (r_phase == PH_SECOND_LETTERS) || (r_phase == PH_SECOND_DIGITS);

    // Accumulate with saturation just above the limit
    assign col_mac = CMW'(r_cacc) * CMW'(COL_RADIX) + CMW'(i_char - CH_A) + CMW'(1);
    assign row_mac = RMW'(r_racc) * RMW'(ROW_RADIX) + RMW'(i_char - CH_0);
    assign col_sat = (col_mac > CMW'(CLIM)) ? (CLIM + CAW'(1)) : col_mac[CAW-1:0];
    assign row_sat = (row_mac > RMW'(RLIM)) ? (RLIM + RAW'(1)) : row_mac[RAW-1:0];

    assign cur_cdec = r_cacc - CAW'(1);
    assign cur_rdec = r_racc - RAW'(1);

    // Next state for one character
    always_comb begin
        n_phase = r_phase;
        n_err   = r_err;
        n_cacc  = r_cacc;
        n_racc  = r_racc;
        n_fr    = r_fr;
        n_fc    = r_fc;
        if (r_err != ERR_MALFORMED) begin
            if (is_letter) begin
                if (letter_ok) begin
                    n_cacc  = col_sat;
                    n_phase = ((r_phase == PH_FIRST_START) || (r_phase == PH_FIRST_LETTERS)) ?
                              PH_FIRST_LETTERS : PH_SECOND_LETTERS;
                end else begin
                    n_err = ERR_MALFORMED;
                end
            end else if (is_digit) begin
                if (digit_ok) begin
                    n_racc  = row_sat;
                    n_phase = ((r_phase == PH_FIRST_LETTERS) || (r_phase == PH_FIRST_DIGITS)) ?
                              PH_FIRST_DIGITS : PH_SECOND_DIGITS;
                end else begin
                    n_err = ERR_MALFORMED;
                end
            end else if (is_colon && i_range_mode && (r_phase == PH_FIRST_DIGITS)) begin
                // Close the first address and keep its corner
                if (addr_in_limit(r_cacc, r_racc)) begin
                    n_fc = cur_cdec[COLUMN_BITS-1:0];
                    n_fr = cur_rdec[ROW_BITS-1:0];
                end else if (r_err == ERR_NONE) begin
                    n_err = ERR_LIMIT;
                end
                n_cacc  = '0;
                n_racc  = '0;
                n_phase = PH_SECOND_START;
            end else begin
                n_err = ERR_MALFORMED;
            end
        end
    end

    // Close the string: final phase and limit checks
    assign want_phase = i_range_mode ? PH_SECOND_DIGITS : PH_FIRST_DIGITS;
    assign fin_cdec   = n_cacc - CAW'(1);
    assign fin_rdec   = n_racc - RAW'(1);

    always_comb begin
        fin_err = n_err;
        if ((fin_err != ERR_MALFORMED) && (n_phase != want_phase)) begin
            fin_err = ERR_MALFORMED;
        end
        if ((fin_err == ERR_NONE) && !addr_in_limit(n_cacc, n_racc)) begin
            fin_err = ERR_LIMIT;
        end
    end

    // Normalize the corners and form the spans
    assign c2     = fin_cdec[COLUMN_BITS-1:0];
    assign r2     = fin_rdec[ROW_BITS-1:0];
    assign c1     = i_range_mode ? n_fc : c2;
    assign r1     = i_range_mode ? n_fr : r2;
    assign c_lo   = (c1 < c2) ? c1 : c2;
    assign c_hi   = (c1 < c2) ? c2 : c1;
    assign r_lo   = (r1 < r2) ? r1 : r2;
    assign r_hi   = (r1 < r2) ? r2 : r1;
    assign c_span = {1'b0, c_hi} - {1'b0, c_lo} + (COLUMN_BITS + 1)'(1);
    assign r_span = {1'b0, r_hi} - {1'b0, r_lo} + (ROW_BITS + 1)'(1);

    // Zero every numeric field unless the string is good
    always_comb begin
        o_result                    = '0;
        o_result.corners.error_code = fin_err;
        if (fin_err == ERR_NONE) begin
            o_result.corners.valid_res   = 1'b1;
            o_result.corners.from_row    = ROW_W'(r_lo);
            o_result.corners.from_column = COL_W'(c_lo);
            o_result.corners.to_row      = ROW_W'(r_hi);
            o_result.corners.to_column   = COL_W'(c_hi);
            o_result.col_span            = CNT_W'(c_span);
            o_result.row_span            = CNT_W'(r_span);
        end
    end

    // Advance on each transfer; the last character clears the parse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_take && i_last)) begin
            r_phase <= PH_FIRST_START;
            r_err   <= ERR_NONE;
            r_cacc  <= '0;
            r_racc  <= '0;
            r_fr    <= '0;
            r_fc    <= '0;
        end else if (i_take) begin
            r_phase <= n_phase;
            r_err   <= n_err;
            r_cacc  <= n_cacc;
            r_racc  <= n_racc;
            r_fr    <= n_fr;
            r_fc    <= n_fc;
        end
    end

endmodule

// File: hdl/crrp_count.sv
// Cell count multiply: column span times row span, modulo 2^CNT_W.
// Three registered partial products of at most 18x18 bits. Uses crrp_pkg.
module crrp_count (
    input  logic                         i_clk,
    input  logic                         i_en,
    input  logic [crrp_pkg::CNT_W-1:0]   i_col_span,
    input  logic [crrp_pkg::CNT_W-1:0]   i_row_span,
    output logic [crrp_pkg::CNT_W-1:0]   o_count
);
    import crrp_pkg::*;

    localparam int HI_W = CNT_W - SPLIT;
    localparam int LL_W = 2 * SPLIT;

    logic [LL_W-1:0]  n_p_ll, r_p_ll;
    logic [CNT_W-1:0] prod_hl, prod_lh;
    logic [HI_W-1:0]  r_p_hl, r_p_lh;

    // Low by low in full; the cross terms only matter below bit HI_W
    assign n_p_ll  = LL_W'(i_col_span[SPLIT-1:0]) * LL_W'(i_row_span[SPLIT-1:0]);
    assign prod_hl = CNT_W'(i_col_span[CNT_W-1:SPLIT]) * CNT_W'(i_row_span[SPLIT-1:0]);
    assign prod_lh = CNT_W'(i_col_span[SPLIT-1:0]) * CNT_W'(i_row_span[CNT_W-1:SPLIT]);

    // Hold the partial products
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p_ll <= n_p_ll;
            r_p_hl <= prod_hl[HI_W-1:0];
            r_p_lh <= prod_lh[HI_W-1:0];
        end
    end

    // Combine the partials
    assign o_count = r_p_ll[CNT_W-1:0] + {HI_W'(r_p_hl + r_p_lh), {SPLIT{1'b0}}};

endmodule

// File: hdl/cell_range_reference_parser.sv
// Spreadsheet cell / range reference parser, one character per transfer.
// The result passes through two result stages (result, multiply) and the output register.
// Throughput: one character per cycle while the master side accepts; these registers decouple.
// Reset (synchronous, active low): parse state cleared, pipeline empty, range_mode = 1.
// Uses crrp_pkg, crrp_parse and crrp_count.
module cell_range_reference_parser #(
    parameter int ROW_BITS    = 20,
    parameter int COLUMN_BITS = 14
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Slave side: tdata = char_code[7:0]; tlast = is_last
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [crrp_pkg::CHAR_W-1:0]         s_axis_tdata,
    input  logic                                s_axis_tlast,
    // Master side: tdata = valid_res[0], error_code[2:1], from_row[22:3],
    // from_column[36:23], to_row[56:37], to_column[70:57], cell_count[105:71], zeros above
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [crrp_pkg::TDATA_OUT_W-1:0]    m_axis_tdata,
    // Configuration: range_mode
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic                                i_cfg_data
);
    import crrp_pkg::*;

    logic             r_range_mode;
    logic             in_xfer, a_go, b_go, o_go;
    t_result          parse_result;
    logic             r_a_valid, r_b_valid, r_o_valid;
    t_result          r_a;
    t_corners         r_b;
    logic [CNT_W-1:0] count;
    logic [TDATA_OUT_W-1:0] r_o_tdata;

    // Configuration register, always ready
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_mode <= 1'b1;
        end else if (i_cfg_valid) begin
            r_range_mode <= i_cfg_data;
        end
    end

    // Stage advance: each stage moves when it is empty or the next one moves
    assign o_go          = !r_o_valid || m_axis_tready;
    assign b_go          = !r_b_valid || o_go;
    assign a_go          = !r_a_valid || b_go;
    assign s_axis_tready = a_go;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    crrp_parse #(
        .ROW_BITS    (ROW_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (in_xfer),
        .i_char       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_range_mode (r_range_mode),
        .o_result     (parse_result)
    );

    // Result stage: capture the finished parse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_go) begin
            r_a_valid <= in_xfer && s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_go) begin
            r_a <= parse_result;
        end
    end

    // Multiply stage: partial products in crrp_count, corners ride along
    crrp_count u_count (
        .i_clk      (i_clk),
        .i_en       (b_go),
        .i_col_span (r_a.col_span),
        .i_row_span (r_a.row_span),
        .o_count    (count)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_go) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_go) begin
            r_b <= r_a.corners;
        end
    end

    // Output register: pack the result item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_go) begin
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_go) begin
            r_o_tdata <= {{PAD_W{1'b0}}, count, r_b.to_column, r_b.to_row,
                          r_b.from_column, r_b.from_row, r_b.error_code, r_b.valid_res};
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = r_o_tdata;

    // A character that is not last never produces a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !s_axis_tlast |=> !r_a_valid)
        else $error("result stage loaded by a non-final character");

    // The last character always produces a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && s_axis_tlast |=> r_a_valid)
        else $error("final character produced no result");

    // valid_res agrees with the error code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] == ERR_NONE)))
        else $error("valid_res and error_code disagree");

    // A rejected reference carries a zero cell count
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> (m_axis_tdata[105:71] == '0))
        else $error("nonzero cell count on an invalid result");

endmodule

// File: verif/tb_top.sv
// Self-checking bench for cell_range_reference_parser: streams reference text one
// character per transfer and checks each result against a cycle-free parse model.
// Depends on crrp_pkg and the cell_range_reference_parser RTL.
module tb_top;
    import crrp_pkg::*;

    localparam int ROW_BITS    = 20;
    localparam int COLUMN_BITS = 14;
    localparam int unsigned COL_LIMIT = 1 << COLUMN_BITS;
    localparam int unsigned ROW_LIMIT = 1 << ROW_BITS;

    // Characters just outside the letter range, the digit range and the colon
    localparam logic [CHAR_W-1:0] CH_AT       = 8'h40;
    localparam logic [CHAR_W-1:0] CH_LBRACKET = 8'h5B;
    localparam logic [CHAR_W-1:0] CH_SLASH    = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_SEMI     = 8'h3B;

    localparam int IDLE_PCT = 36;

    typedef struct packed {
        logic             ok;
        t_err             code;
        logic [ROW_W-1:0] from_row;
        logic [COL_W-1:0] from_col;
        logic [ROW_W-1:0] to_row;
        logic [COL_W-1:0] to_col;
        logic [CNT_W-1:0] cells;
    } t_cell_range;

    // One directed reference: its mode, where its text sits, and an optional typed result
    typedef struct packed {
        bit          span_mode;
        int          first;
        int          len;
        bit          typed;
        t_cell_range result;
    } t_dir_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [CHAR_W-1:0]      s_axis_tdata  = '0;     // char_code[7:0]
    logic                   s_axis_tlast  = 1'b0;   // is_last
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // valid_res[0], error_code[2:1], from_row[22:3], from_column[36:23],
    // to_row[56:37], to_column[70:57], cell_count[105:71], zeros above
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic                   i_cfg_data  = 1'b0;

    cell_range_reference_parser #(
        .ROW_BITS    (ROW_BITS),
        .COLUMN_BITS (COLUMN_BITS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Parse model state
    bit          range_on = 1'b1;
    t_phase      scan_phase = PH_FIRST_START;
    int unsigned col_value, row_value;
    logic [ROW_W-1:0] anchor_row;
    logic [COL_W-1:0] anchor_col;
    t_err        flaw = ERR_NONE;

    t_cell_range pending_refs[$];
    t_dir_row    dir_rows[$];
    byte unsigned dir_text[$];
    byte unsigned text_buf[$];
    bit          calm = 1'b0;
    int          chars_sent = 0;
    int          faults = 0;
    t_cell_range seen_ref, want_ref;

    function automatic void clear_scan();
        scan_phase = PH_FIRST_START;
        col_value  = 0;
        row_value  = 0;
        anchor_row = '0;
        anchor_col = '0;
        flaw       = ERR_NONE;
    endfunction

    // Limit check of the address held in the accumulators; a limit error never
    // overrides malformed text
    function automatic bit address_in_limits();
        if (col_value > COL_LIMIT || row_value == 0 || row_value > ROW_LIMIT) begin
            if (flaw == ERR_NONE) flaw = ERR_LIMIT;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    // Advance the parse by one character; on the last one produce the range
    function automatic void parse_char(input byte unsigned c, input bit last,
                                       output bit has_res, output t_cell_range res);
        int unsigned acc;
        logic [ROW_W-1:0] r1, r2;
        logic [COL_W-1:0] c1, c2;
        longint unsigned cspan, rspan;
        t_phase want_phase;
        has_res = 1'b0;
        res = '0;
        if (flaw != ERR_MALFORMED) begin
            if (c >= CH_A && c <= CH_Z) begin
                if (scan_phase == PH_FIRST_START || scan_phase == PH_FIRST_LETTERS ||
                    scan_phase == PH_SECOND_START || scan_phase == PH_SECOND_LETTERS) begin
                    acc = col_value * COL_RADIX + (c - CH_A + 1);
                    col_value = (acc > COL_LIMIT) ? COL_LIMIT + 1 : acc;
                    scan_phase = (scan_phase == PH_FIRST_START ||
                                  scan_phase == PH_FIRST_LETTERS) ?
                                 PH_FIRST_LETTERS : PH_SECOND_LETTERS;
                end else begin
                    flaw = ERR_MALFORMED;
                end
            end else if (c >= CH_0 && c <= CH_9) begin
                if (scan_phase == PH_FIRST_LETTERS || scan_phase == PH_FIRST_DIGITS ||
                    scan_phase == PH_SECOND_LETTERS || scan_phase == PH_SECOND_DIGITS) begin
                    acc = row_value * ROW_RADIX + (c - CH_0);
                    row_value = (acc > ROW_LIMIT) ? ROW_LIMIT + 1 : acc;
                    scan_phase = (scan_phase == PH_FIRST_LETTERS ||
                                  scan_phase == PH_FIRST_DIGITS) ?
                                 PH_FIRST_DIGITS : PH_SECOND_DIGITS;
                end else begin
                    flaw = ERR_MALFORMED;
                end
            end else if (c == CH_COLON && range_on && scan_phase == PH_FIRST_DIGITS) begin
                if (address_in_limits()) begin
                    anchor_col = COL_W'(col_value - 1);
                    anchor_row = ROW_W'(row_value - 1);
                end
                col_value  = 0;
                row_value  = 0;
                scan_phase = PH_SECOND_START;
            end else begin
                flaw = ERR_MALFORMED;
            end
        end
        if (!last) return;

        // Close the string: it must end in the digits of its final address
        want_phase = range_on ? PH_SECOND_DIGITS : PH_FIRST_DIGITS;
        if (flaw != ERR_MALFORMED && scan_phase != want_phase) flaw = ERR_MALFORMED;
        if (flaw != ERR_MALFORMED && address_in_limits() && flaw == ERR_NONE) begin
            r2 = ROW_W'(row_value - 1);
            c2 = COL_W'(col_value - 1);
            r1 = range_on ? anchor_row : r2;
            c1 = range_on ? anchor_col : c2;
            res.from_row = (r1 < r2) ? r1 : r2;
            res.to_row   = (r1 < r2) ? r2 : r1;
            res.from_col = (c1 < c2) ? c1 : c2;
            res.to_col   = (c1 < c2) ? c2 : c1;
            cspan = 64'(res.to_col) - 64'(res.from_col) + 64'd1;
            rspan = 64'(res.to_row) - 64'(res.from_row) + 64'd1;
            res.cells = CNT_W'(cspan * rspan);
        end
        res.ok   = (flaw == ERR_NONE);
        res.code = flaw;
        if (flaw != ERR_NONE) begin
            res.from_row = '0;
            res.from_col = '0;
            res.to_row   = '0;
            res.to_col   = '0;
            res.cells    = '0;
        end
        has_res = 1'b1;
        clear_scan();
    endfunction

    function automatic t_cell_range failed_as(input t_err code);
        t_cell_range r;
        r = '0;
        r.code = code;
        return r;
    endfunction

    task automatic add_row(input bit span_mode, input string text, input byte unsigned raw,
                           input bit typed, input t_cell_range result);
        t_dir_row row;
        int k;
        row.span_mode = span_mode;
        row.first     = dir_text.size();
        row.typed     = typed;
        row.result    = result;
        if (text.len() == 0) begin
            dir_text.push_back(raw);
        end else begin
            for (k = 0; k < text.len(); k++) dir_text.push_back(text.getc(k));
        end
        row.len = dir_text.size() - row.first;
        dir_rows.push_back(row);
    endtask

    function automatic byte unsigned stray_char();
        case ($urandom_range(4))
            0: return 8'(CH_A + $urandom_range(25));
            1: return 8'(CH_0 + $urandom_range(9));
            2: return CH_COLON;
            3: return 8'($urandom_range(255));
            default: begin
                case ($urandom_range(3))
                    0: return CH_AT;
                    1: return CH_LBRACKET;
                    2: return CH_SLASH;
                    default: return CH_SEMI;
                endcase
            end
        endcase
    endfunction

    // Append column letters: mostly short, some at the limit, some long enough to saturate
    task automatic append_column();
        int unsigned v;
        int r;
        byte unsigned tmp[$];
        r = $urandom_range(99);
        if (r >= 94) begin
            repeat ($urandom_range(4, 7)) text_buf.push_back(8'(CH_A + $urandom_range(25)));
        end else begin
            if (r < 60)      v = $urandom_range(1, 60);
            else if (r < 78) v = $urandom_range(1, COL_LIMIT);
            else if (r < 90) v = $urandom_range(COL_LIMIT - 1, COL_LIMIT + 2);
            else             v = $urandom_range(600, 20000);
            while (v > 0) begin
                v = v - 1;
                tmp.push_front(8'(CH_A + v % COL_RADIX));
                v = v / COL_RADIX;
            end
            foreach (tmp[k]) text_buf.push_back(tmp[k]);
        end
    endtask

    // Append row digits, including zero, leading zeros and runs past the limit
    task automatic append_row();
        int unsigned v;
        int r, k;
        string s;
        r = $urandom_range(99);
        if (r >= 93) begin
            repeat ($urandom_range(7, 10)) text_buf.push_back(8'(CH_0 + $urandom_range(9)));
        end else begin
            if (r < 50)      v = $urandom_range(1, 200);
            else if (r < 70) v = $urandom_range(1, ROW_LIMIT);
            else if (r < 80) v = $urandom_range(ROW_LIMIT - 1, ROW_LIMIT + 2);
            else if (r < 86) v = 0;
            else begin
                v = $urandom_range(1, 99);
                repeat ($urandom_range(1, 3)) text_buf.push_back(CH_0);
            end
            s = $sformatf("%0d", v);
            for (k = 0; k < s.len(); k++) text_buf.push_back(s.getc(k));
        end
    endtask

    // Build one reference string: mostly well formed, some in the other form,
    // some damaged and a few pure noise
    task automatic build_reference(input bit span_mode);
        int kind, idx;
        bit two_part;
        text_buf.delete();
        kind = $urandom_range(99);
        if (kind < 6) begin
            repeat ($urandom_range(1, 6)) text_buf.push_back(stray_char());
            return;
        end
        two_part = (kind < 14) ? !span_mode : span_mode;
        append_column();
        append_row();
        if (two_part) begin
            text_buf.push_back(CH_COLON);
            append_column();
            append_row();
        end
        if (kind >= 80) begin
            case ($urandom_range(2))
                0: begin
                    idx = $urandom_range(text_buf.size() - 1);
                    text_buf[idx] = stray_char();
                end
                1: begin
                    idx = $urandom_range(1, text_buf.size() - 1);
                    while (text_buf.size() > idx) void'(text_buf.pop_back());
                end
                default: text_buf.push_back(stray_char());
            endcase
        end
    endtask

    // Drive one character with a random gap ahead of it and wait for its transfer
    task automatic send_char(input byte unsigned c, input bit last,
                             output bit has_res, output t_cell_range res);
        int gap;
        gap = 0;
        while (!calm && $urandom_range(99) < IDLE_PCT) gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        chars_sent++;
        parse_char(c, last, has_res, res);
    endtask

    task automatic send_text();
        bit has_res;
        t_cell_range res;
        int k;
        for (k = 0; k < text_buf.size(); k++) begin
            send_char(text_buf[k], k == text_buf.size() - 1, has_res, res);
            if (has_res) pending_refs.push_back(res);
        end
    endtask

    // Write range_mode once the block has drained: hold the sender until every
    // expected result is back, then let the pipeline settle
    task automatic write_mode(input bit m);
        s_axis_tvalid <= 1'b0;
        while (pending_refs.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= m;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        range_on = m;
    endtask

    // Result side: random backpressure, then compare each transfer with the oldest expectation
    always @(posedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_ref.ok       = m_axis_tdata[0];
            seen_ref.code     = t_err'(m_axis_tdata[2:1]);
            seen_ref.from_row = m_axis_tdata[22:3];
            seen_ref.from_col = m_axis_tdata[36:23];
            seen_ref.to_row   = m_axis_tdata[56:37];
            seen_ref.to_col   = m_axis_tdata[70:57];
            seen_ref.cells    = m_axis_tdata[105:71];
            if (pending_refs.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result: ok=%0d err=%0d", seen_ref.ok, seen_ref.code);
            end else begin
                want_ref = pending_refs.pop_front();
                if (seen_ref.ok !== want_ref.ok || seen_ref.code !== want_ref.code ||
                    seen_ref.from_row !== want_ref.from_row ||
                    seen_ref.from_col !== want_ref.from_col ||
                    seen_ref.to_row !== want_ref.to_row ||
                    seen_ref.to_col !== want_ref.to_col ||
                    seen_ref.cells !== want_ref.cells) begin
                    faults++;
                    if (faults <= 10) begin
                        $display("mismatch exp: ok=%0d err=%0d from=(%0d,%0d) to=(%0d,%0d) n=%0d",
                                 want_ref.ok, want_ref.code, want_ref.from_row,
                                 want_ref.from_col, want_ref.to_row, want_ref.to_col,
                                 want_ref.cells);
                        $display("         got: ok=%0d err=%0d from=(%0d,%0d) to=(%0d,%0d) n=%0d",
                                 seen_ref.ok, seen_ref.code, seen_ref.from_row,
                                 seen_ref.from_col, seen_ref.to_row, seen_ref.to_col,
                                 seen_ref.cells);
                    end
                end
            end
        end
    end

    initial begin : stimulus
        t_dir_row row;
        bit has_res;
        t_cell_range res;
        int i, k, p, budget;

        clear_scan();

        // Directed references; range mode first, as left by reset
        add_row(1'b1, "A1:XFD1048576", 8'h00, 1'b1,
                '{1'b1, ERR_NONE, 20'd0, 14'd0, 20'hFFFFF, 14'h3FFF, 35'h4_0000_0000});
        // Row zero before the colon, then a digit where letters belong
        add_row(1'b1, "A0:1", 8'h00, 1'b1, failed_as(ERR_MALFORMED));
        add_row(1'b1, "", 8'h00, 1'b1, failed_as(ERR_MALFORMED));
        // Range mode without a colon
        add_row(1'b1, "A1", 8'h00, 1'b1, failed_as(ERR_MALFORMED));
        // Column one past the last
        add_row(1'b0, "XFE1", 8'h00, 1'b1, failed_as(ERR_LIMIT));
        add_row(1'b0, "A1:", 8'h00, 1'b1, failed_as(ERR_MALFORMED));
        add_row(1'b0, "", 8'hFF, 1'b1, failed_as(ERR_MALFORMED));
        add_row(1'b0, "A0", 8'h00, 1'b1, failed_as(ERR_LIMIT));
        add_row(1'b0, "1A", 8'h00, 1'b1, failed_as(ERR_MALFORMED));

        i_rst_n <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < dir_rows.size(); i++) begin
            row = dir_rows[i];
            if (row.span_mode != range_on) write_mode(row.span_mode);
            for (k = 0; k < row.len; k++) begin
                send_char(dir_text[row.first + k], k == row.len - 1, has_res, res);
                if (has_res) pending_refs.push_back(row.typed ? row.result : res);
            end
        end

        // Random phases alternate the mode; the middle one runs without idling
        for (p = 0; p < 5; p++) begin
            write_mode(p % 2 == 0);
            calm = (p == 2);
            budget = chars_sent + 80;
            while (chars_sent < budget) begin
                build_reference(range_on);
                send_text();
            end
        end
        calm = 1'b0;

        s_axis_tvalid <= 1'b0;
        while (pending_refs.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (faults == 0)
            $display("PASS cell_range_reference_parser");
        else
            $display("FAIL cell_range_reference_parser");
        $finish;
    end

    // Bound the run well beyond the slowest legal schedule
    initial begin
        #400000;
        $display("FAIL cell_range_reference_parser");
        $finish;
    end

endmodule

// File: cell_range_reference_parser.f
hdl/crrp_pkg.sv
hdl/crrp_parse.sv
hdl/crrp_count.sv
hdl/cell_range_reference_parser.sv
verif/tb_top.sv
